>>> sv/dtss_pkg.sv
// ----------------------------------------------------------------------------
// dtss_pkg
// Shared types and constants for the drum trigger step sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package dtss_pkg;

  // Sequence length and derived step-word constants
  localparam int STEPS = 16;
  localparam int MASK_W = (STEPS < 16) ? STEPS : 16;
  localparam logic [STEPS-1:0] TOP_STEP = STEPS'(1) << (STEPS - 1);
  localparam logic [STEPS-1:0] RESET_STEP_WORD = TOP_STEP | STEPS'(1);
  localparam logic [STEPS-1:0] DOWNBEAT_BITS = STEPS'(64'h8888_8888_8888_8888);

  // Field widths
  localparam int LINES_W = 5;
  localparam int POS_W   = 16;
  localparam int CNT_W   = 16;
  localparam int LEN_W   = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KICK_MASK       = 3'd0,
    CFG_SNARE_MASK      = 3'd1,
    CFG_CLOSED_HAT_MASK = 3'd2,
    CFG_OPEN_HAT_MASK   = 3'd3,
    CFG_TRIGGER_LENGTH  = 3'd4,
    CFG_LOCKOUT_LENGTH  = 3'd5,
    CFG_IDLE_LIMIT      = 3'd6,
    CFG_HOLD_LIMIT      = 3'd7
  } cfg_idx_e;

  // Reset values of the configuration registers
  localparam logic [LEN_W-1:0] TRIGGER_LENGTH_RST  = LEN_W'(20);
  localparam logic [LEN_W-1:0] LOCKOUT_LENGTH_RST  = LEN_W'(20);
  localparam logic [CNT_W-1:0] IDLE_LIMIT_RST      = CNT_W'(3000);
  localparam logic [CNT_W-1:0] HOLD_LIMIT_RST      = CNT_W'(500);

  typedef struct packed {
    logic [15:0]      kick_mask;
    logic [15:0]      snare_mask;
    logic [15:0]      closed_hat_mask;
    logic [15:0]      open_hat_mask;
    logic [LEN_W-1:0] trigger_length;
    logic [LEN_W-1:0] lockout_length;
    logic [CNT_W-1:0] idle_limit;
    logic [CNT_W-1:0] hold_limit;
  } cfg_t;

  // One tick item
  typedef struct packed {
    logic clock_edge;
    logic button_level;
  } tick_t;

  // One result item
  typedef struct packed {
    logic [LINES_W-1:0] trigger_lines;
    logic [POS_W-1:0]   step_position;
    logic               reroll_request;
    logic               restarted;
  } result_t;

endpackage : dtss_pkg

`default_nettype wire

>>> sv/dtss_cfg_regs.sv
// ----------------------------------------------------------------------------
// dtss_cfg_regs
// Configuration register file: pattern masks and timing values.
// ----------------------------------------------------------------------------
`default_nettype none

module dtss_cfg_regs
  import dtss_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Register write decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kick_mask       <= '0;
      cfg_q.snare_mask      <= '0;
      cfg_q.closed_hat_mask <= '0;
      cfg_q.open_hat_mask   <= '0;
      cfg_q.trigger_length  <= TRIGGER_LENGTH_RST;
      cfg_q.lockout_length  <= LOCKOUT_LENGTH_RST;
      cfg_q.idle_limit      <= IDLE_LIMIT_RST;
      cfg_q.hold_limit      <= HOLD_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_KICK_MASK:       cfg_q.kick_mask       <= cfg_data_i;
        CFG_SNARE_MASK:      cfg_q.snare_mask      <= cfg_data_i;
        CFG_CLOSED_HAT_MASK: cfg_q.closed_hat_mask <= cfg_data_i;
        CFG_OPEN_HAT_MASK:   cfg_q.open_hat_mask   <= cfg_data_i;
        CFG_TRIGGER_LENGTH:  cfg_q.trigger_length  <= cfg_data_i[LEN_W-1:0];
        CFG_LOCKOUT_LENGTH:  cfg_q.lockout_length  <= cfg_data_i[LEN_W-1:0];
        CFG_IDLE_LIMIT:      cfg_q.idle_limit      <= cfg_data_i;
        CFG_HOLD_LIMIT:      cfg_q.hold_limit      <= cfg_data_i;
      endcase
    end
  end

endmodule : dtss_cfg_regs

`default_nettype wire

>>> sv/dtss_in_reg.sv
// ----------------------------------------------------------------------------
// dtss_in_reg
// Input register: holds one tick item until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dtss_in_reg
  import dtss_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire tick_t item_i,
  input  wire logic  take_i,
  output logic       valid_o,
  output tick_t      item_o
);

  logic  valid_q;
  logic  valid_d;
  tick_t item_q;
  logic  load;

  // Room when empty or when the held item leaves this cycle
  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule : dtss_in_reg

`default_nettype wire

>>> sv/dtss_core.sv
// ----------------------------------------------------------------------------
// dtss_core
// Sequencer state and the per-tick update: clock lockout, triggers,
// step rotation, button handling and auto-reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dtss_core
  import dtss_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  fire_i,
  input  wire tick_t item_i,
  input  wire cfg_t  cfg_i,
  output result_t    result_o
);

  logic [STEPS-1:0]   step_q, step_d;
  logic               pend_q, pend_d;
  logic               lock_q, lock_d;
  logic               trig_q, trig_d;
  logic [LINES_W-1:0] lines_q, lines_d;
  logic [CNT_W-1:0]   tsc_q, tsc_d;
  logic [CNT_W-1:0]   tsa_q, tsa_d;
  logic               prev_q, prev_d;
  logic [CNT_W-1:0]   press_q, press_d;
  logic               accept;
  logic               reroll;
  logic               restart;
  logic [LINES_W-1:0] hits;

  // Trigger hits for the current step
  assign hits = {
    |(step_q[MASK_W-1:0] & cfg_i.open_hat_mask[MASK_W-1:0]),
    |(step_q[MASK_W-1:0] & cfg_i.closed_hat_mask[MASK_W-1:0]),
    |(step_q[MASK_W-1:0] & cfg_i.snare_mask[MASK_W-1:0]),
    |(step_q[MASK_W-1:0] & cfg_i.kick_mask[MASK_W-1:0]),
    |(step_q & DOWNBEAT_BITS)
  };

  assign accept = (pend_q || item_i.clock_edge) && !lock_q;

  // Next-state logic for one tick
  always_comb begin
    reroll  = 1'b0;
    restart = 1'b0;
    step_d  = step_q;
    lock_d  = lock_q;
    trig_d  = trig_q;
    lines_d = lines_q;
    prev_d  = prev_q;
    tsc_d   = (tsc_q == CNT_SAT) ? tsc_q : tsc_q + CNT_W'(1);
    tsa_d   = (tsa_q == CNT_SAT) ? tsa_q : tsa_q + CNT_W'(1);
    press_d = (press_q == CNT_SAT) ? press_q : press_q + CNT_W'(1);
    pend_d  = pend_q || item_i.clock_edge;

    // Accepted clock: fire lines, rotate step
    if (accept) begin
      lines_d = lines_q | hits;
      step_d  = step_q >> 1;
      if (step_d == '0) begin
        step_d = TOP_STEP;
      end
      pend_d = 1'b0;
      lock_d = 1'b1;
      trig_d = 1'b1;
      tsc_d  = '0;
      tsa_d  = '0;
    end

    // Trigger and lockout timeouts
    if (trig_d && (tsc_d > CNT_W'(cfg_i.trigger_length))) begin
      lines_d = '0;
      trig_d  = 1'b0;
    end
    if (lock_d && (tsc_d > CNT_W'(cfg_i.lockout_length))) begin
      lock_d = 1'b0;
    end

    // Button press and release
    if (item_i.button_level != prev_q) begin
      if (!item_i.button_level) begin
        press_d = '0;
      end else if (press_d > cfg_i.hold_limit) begin
        reroll = 1'b1;
      end else begin
        restart = 1'b1;
      end
      prev_d = item_i.button_level;
    end
    if (restart) begin
      step_d = RESET_STEP_WORD;
      pend_d = 1'b0;
      tsa_d  = '0;
    end

    // Auto-reset after a long silence
    if ((tsa_d > cfg_i.idle_limit) && (step_d != RESET_STEP_WORD)) begin
      restart = 1'b1;
      step_d  = RESET_STEP_WORD;
      pend_d  = 1'b0;
      tsa_d   = '0;
    end
  end

  // State registers, updated once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= RESET_STEP_WORD;
      pend_q  <= 1'b0;
      lock_q  <= 1'b0;
      trig_q  <= 1'b0;
      lines_q <= '0;
      tsc_q   <= '0;
      tsa_q   <= '0;
      prev_q  <= 1'b1;
      press_q <= '0;
    end else if (fire_i) begin
      step_q  <= step_d;
      pend_q  <= pend_d;
      lock_q  <= lock_d;
      trig_q  <= trig_d;
      lines_q <= lines_d;
      tsc_q   <= tsc_d;
      tsa_q   <= tsa_d;
      prev_q  <= prev_d;
      press_q <= press_d;
    end
  end

  assign result_o.trigger_lines  = lines_d;
  assign result_o.step_position  = POS_W'(step_d);
  assign result_o.reroll_request = reroll;
  assign result_o.restarted      = restart;

  // Step word is one-hot or the two-bit reset step
  a_step_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(step_q) || (step_q == RESET_STEP_WORD))
    else $error("step word lost its shape");

  // Lines are low whenever no trigger is active
  a_lines_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !trig_q |-> (lines_q == '0))
    else $error("trigger lines high without active trigger");

  // An accepted clock starts the lockout
  a_lockout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && accept) |=> lock_q)
    else $error("accepted clock did not start lockout");

  // A restart leaves the reset step behind
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && restart) |=> (step_q == RESET_STEP_WORD) && !pend_q)
    else $error("restart did not reach reset step");

endmodule : dtss_core

`default_nettype wire

>>> sv/dtss_out_reg.sv
// ----------------------------------------------------------------------------
// dtss_out_reg
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dtss_out_reg
  import dtss_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t result_i,
  output logic         room_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      result_o
);

  logic    valid_q;
  logic    valid_d;
  result_t result_q;

  // Free when empty or when the held result is taken now
  assign room_o  = !valid_q || out_ready_i;
  assign valid_d = load_i ? 1'b1 : ((valid_q && out_ready_i) ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule : dtss_out_reg

`default_nettype wire

>>> sv/drum_trigger_step_sequencer_top.sv
// ----------------------------------------------------------------------------
// drum_trigger_step_sequencer_top
// Tick-driven 16-step drum trigger sequencer with lockout, trigger timing,
// button restart / reroll and auto-reset.
// ----------------------------------------------------------------------------
//  channel | handshake               | fields
//  --------+-------------------------+-------------------------------------------------------
//  in      | in_valid_i/in_ready_o   | clock_edge, button_level
//  out     | out_valid_o/out_ready_i | trigger_lines, step_position, reroll_request, restarted
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_index, cfg_data
//
// One tick per cycle while the consumer does not stall the output; each tick passes
// through the input register, then the state update into the result register.
// The throughput is set by the state update in the core.
// Reset is asynchronous active low and puts the sequence at the reset step.
// A stalled output holds its result and backs up the input register; both
// stages refill in the cycle the consumer takes the result.
// ----------------------------------------------------------------------------
`default_nettype none

module drum_trigger_step_sequencer_top
  import dtss_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  clock_edge_i,
  input  wire logic                  button_level_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [LINES_W-1:0]         trigger_lines_o,
  output logic [POS_W-1:0]           step_position_o,
  output logic                       reroll_request_o,
  output logic                       restarted_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t    cfg;
  tick_t   in_item;
  tick_t   held_item;
  logic    held_valid;
  logic    out_room;
  logic    fire;
  result_t core_result;
  result_t out_result;

  assign in_item.clock_edge   = clock_edge_i;
  assign in_item.button_level = button_level_i;

  // Core consumes the held tick when the result register has room
  assign fire = held_valid && out_room;

  dtss_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dtss_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .take_i     (fire),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  dtss_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (held_item),
    .cfg_i    (cfg),
    .result_o (core_result)
  );

  dtss_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .result_i    (core_result),
    .room_o      (out_room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_result)
  );

  assign trigger_lines_o  = out_result.trigger_lines;
  assign step_position_o  = out_result.step_position;
  assign reroll_request_o = out_result.reroll_request;
  assign restarted_o      = out_result.restarted;

endmodule : drum_trigger_step_sequencer_top

`default_nettype wire

>>> dv/drum_trigger_step_sequencer_top_tb.sv
// ----------------------------------------------------------------------------
// drum_trigger_step_sequencer_top_tb
// Self-checking bench for the tick-driven drum trigger step sequencer. A
// scoreboard predicts every result from its own copy of the sequencer state
// and registers. Ticks come as clock and button patterns under several
// register settings, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module drum_trigger_step_sequencer_top_tb;

  import dtss_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int CYCLE_LIMIT = 2_000_000;

  // Predicts one result per tick and checks results in order
  class step_scoreboard;
    cfg_t               regs;
    logic [STEPS-1:0]   step_word;
    bit                 clock_pending;
    bit                 in_lockout;
    bit                 trigger_active;
    bit                 button_prev;
    logic [LINES_W-1:0] line_levels;
    logic [CNT_W-1:0]   since_clock;
    logic [CNT_W-1:0]   since_activity;
    logic [CNT_W-1:0]   press_ticks;
    result_t            due_results[$];
    int                 mismatches;

    function new();
      regs                 = '0;
      regs.trigger_length  = TRIGGER_LENGTH_RST;
      regs.lockout_length  = LOCKOUT_LENGTH_RST;
      regs.idle_limit      = IDLE_LIMIT_RST;
      regs.hold_limit      = HOLD_LIMIT_RST;
      step_word      = RESET_STEP_WORD;
      clock_pending  = 0;
      in_lockout     = 0;
      trigger_active = 0;
      button_prev    = 1;
      line_levels    = '0;
      since_clock    = '0;
      since_activity = '0;
      press_ticks    = '0;
      mismatches     = 0;
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
      return (v == CNT_SAT) ? v : v + CNT_W'(1);
    endfunction

    // Back to the home step; lockout and trigger lines are left alone
    function void go_home();
      step_word      = RESET_STEP_WORD;
      clock_pending  = 0;
      since_activity = '0;
    endfunction

    function void note_config(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_KICK_MASK:       regs.kick_mask       = data;
        CFG_SNARE_MASK:      regs.snare_mask      = data;
        CFG_CLOSED_HAT_MASK: regs.closed_hat_mask = data;
        CFG_OPEN_HAT_MASK:   regs.open_hat_mask   = data;
        CFG_TRIGGER_LENGTH:  regs.trigger_length  = data[LEN_W-1:0];
        CFG_LOCKOUT_LENGTH:  regs.lockout_length  = data[LEN_W-1:0];
        CFG_IDLE_LIMIT:      regs.idle_limit      = data;
        CFG_HOLD_LIMIT:      regs.hold_limit      = data;
        default: ;
      endcase
    endfunction

    // Advance the predicted state by one accepted tick
    function void note_tick(logic clk_edge, logic btn_level);
      result_t            r;
      logic [LINES_W-1:0] hits;
      r    = '0;
      hits = '0;
      since_clock    = bump(since_clock);
      since_activity = bump(since_activity);
      press_ticks    = bump(press_ticks);
      if (clk_edge) clock_pending = 1;

      // Clock taken: fire lines for the current step, then rotate
      if (clock_pending && !in_lockout) begin
        hits[0] = |(step_word & DOWNBEAT_BITS);
        hits[1] = |(step_word[MASK_W-1:0] & regs.kick_mask[MASK_W-1:0]);
        hits[2] = |(step_word[MASK_W-1:0] & regs.snare_mask[MASK_W-1:0]);
        hits[3] = |(step_word[MASK_W-1:0] & regs.closed_hat_mask[MASK_W-1:0]);
        hits[4] = |(step_word[MASK_W-1:0] & regs.open_hat_mask[MASK_W-1:0]);
        line_levels = line_levels | hits;
        step_word   = step_word >> 1;
        if (step_word == '0) step_word = TOP_STEP;
        clock_pending  = 0;
        in_lockout     = 1;
        trigger_active = 1;
        since_clock    = '0;
        since_activity = '0;
      end

      if (trigger_active && since_clock > CNT_W'(regs.trigger_length)) begin
        line_levels    = '0;
        trigger_active = 0;
      end
      if (in_lockout && since_clock > CNT_W'(regs.lockout_length)) in_lockout = 0;

      // Button: press starts timing, release decides reroll or restart
      if (btn_level != button_prev) begin
        if (!btn_level) begin
          press_ticks = '0;
        end else if (press_ticks > regs.hold_limit) begin
          r.reroll_request = 1'b1;
        end else begin
          go_home();
          r.restarted = 1'b1;
        end
        button_prev = btn_level;
      end

      if (since_activity > regs.idle_limit && step_word != RESET_STEP_WORD) begin
        go_home();
        r.restarted = 1'b1;
      end

      r.trigger_lines = line_levels;
      r.step_position = POS_W'(step_word);
      due_results.push_back(r);
    endfunction

    task report(string what, logic [31:0] want, logic [31:0] got);
      $display("%0t ns: MISMATCH %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        report("result with no tick outstanding", '0, 32'(got));
        return;
      end
      want = due_results.pop_front();
      if (got.trigger_lines !== want.trigger_lines)
        report("trigger_lines", 32'(want.trigger_lines), 32'(got.trigger_lines));
      if (got.step_position !== want.step_position)
        report("step_position", 32'(want.step_position), 32'(got.step_position));
      if (got.reroll_request !== want.reroll_request)
        report("reroll_request", 32'(want.reroll_request), 32'(got.reroll_request));
      if (got.restarted !== want.restarted)
        report("restarted", 32'(want.restarted), 32'(got.restarted));
    endtask

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic                  clock_edge_i   = 1'b0;
  logic                  button_level_i = 1'b1;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic [LINES_W-1:0]    trigger_lines_o;
  logic [POS_W-1:0]      step_position_o;
  logic                  reroll_request_o;
  logic                  restarted_o;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;

  step_scoreboard sb;
  bit             gaps_on    = 1'b1;
  int             stall_left = 0;
  int             cycles     = 0;
  result_t        seen_result;

  drum_trigger_step_sequencer_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .clock_edge_i     (clock_edge_i),
    .button_level_i   (button_level_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .trigger_lines_o  (trigger_lines_o),
    .step_position_o  (step_position_o),
    .reroll_request_o (reroll_request_o),
    .restarted_o      (restarted_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Run guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("drum_trigger_step_sequencer_top test failed");
      $finish;
    end
  end

  // Result side: check each transaction, stall in short random bursts
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      seen_result.trigger_lines  = trigger_lines_o;
      seen_result.step_position  = step_position_o;
      seen_result.reroll_request = reroll_request_o;
      seen_result.restarted      = restarted_o;
      sb.check_result(seen_result);
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // One tick transaction, with an optional idle burst ahead of it
  task automatic send_tick(input logic clk_edge, input logic btn_level);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    clock_edge_i   <= clk_edge;
    button_level_i <= btn_level;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_tick(clk_edge, btn_level);
  endtask

  // Hold off ticks until every result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.note_config(idx, data);
  endtask

  task automatic load_settings(input logic [15:0] kick, snare, closed_hat, open_hat,
                               input logic [15:0] trig_len, lock_len, idle_t, hold_t);
    drain();
    write_reg(CFG_KICK_MASK, kick);
    write_reg(CFG_SNARE_MASK, snare);
    write_reg(CFG_CLOSED_HAT_MASK, closed_hat);
    write_reg(CFG_OPEN_HAT_MASK, open_hat);
    write_reg(CFG_TRIGGER_LENGTH, trig_len);
    write_reg(CFG_LOCKOUT_LENGTH, lock_len);
    write_reg(CFG_IDLE_LIMIT, idle_t);
    write_reg(CFG_HOLD_LIMIT, hold_t);
    cfg_valid_i <= 1'b0;
  endtask

  // Steady clock with jitter and dropouts, button presses of short, boundary
  // and long length, plus stray edges and button glitches
  task automatic play_pattern(input int n, input int hold_t, input int idle_t, input int lock_t);
    int   period;
    int   clk_cnt;
    int   press_left;
    int   lim;
    logic e;
    logic b;
    period     = $urandom_range(1, ((lock_t > 8) ? 8 : lock_t) + 6);
    clk_cnt    = 0;
    press_left = 0;
    lim        = (hold_t > 250) ? 250 : hold_t;
    for (int i = 0; i < n; i++) begin
      // halfway through, let the sequencer run dry once
      if (i == n / 2) drain();
      if (clk_cnt == 0) begin
        e       = 1'b1;
        clk_cnt = period + $urandom_range(0, 1);
        if ($urandom_range(0, 59) == 0)
          clk_cnt = ((idle_t > 250) ? 250 : idle_t) + $urandom_range(0, 4);
      end else begin
        e = ($urandom_range(0, 29) == 0);
        clk_cnt--;
      end
      if (press_left == 0 && $urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 2))
          0:       press_left = $urandom_range(1, (lim > 1) ? lim : 1);
          1:       press_left = lim + $urandom_range(0, 1);
          default: press_left = lim + $urandom_range(1, 10);
        endcase
      end
      if (press_left > 0) begin
        b = 1'b0;
        press_left--;
      end else begin
        b = 1'b1;
      end
      if ($urandom_range(0, 79) == 0) b = ~b;
      send_tick(e, b);
    end
  endtask

  initial begin
    logic [9:0]  trig_len;
    logic [9:0]  lock_len;
    logic [15:0] idle_t;
    logic [15:0] hold_t;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: latched edge waits out the lockout, lines
    // expire, then a short press sends the sequence home
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    repeat (21) send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);

    // Lowest settings: zero times expire after one tick, all masks full
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, '0, '0, '0, '0);
    play_pattern(60, 0, 0, 0);

    // Highest settings, with stray upper bits on the 10-bit lengths
    load_settings(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    play_pattern(80, 65535, 65535, 1023);

    // Long-press release on the same tick as an auto-reset
    load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'd3, 16'd4, 16'd30, 16'd10);
    repeat (40) send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    repeat (30) send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    play_pattern(150, 10, 30, 4);

    // Random settings; the middle and last phases run without idling
    for (int p = 0; p < 5; p++) begin
      gaps_on  = (p != 2) && (p != 4);
      trig_len = 10'($urandom_range(0, 10));
      lock_len = 10'($urandom_range(0, 8));
      idle_t   = 16'($urandom_range(4, 60));
      hold_t   = 16'($urandom_range(0, 20));
      load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    {6'($urandom), trig_len}, {6'($urandom), lock_len}, idle_t, hold_t);
      play_pattern(140, int'(hold_t), int'(idle_t), int'(lock_len));
    end

    drain();
    repeat (6) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("drum_trigger_step_sequencer_top test passed");
    end else begin
      $display("drum_trigger_step_sequencer_top test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/dtss_pkg.sv
sv/dtss_cfg_regs.sv
sv/dtss_in_reg.sv
sv/dtss_core.sv
sv/dtss_out_reg.sv
sv/drum_trigger_step_sequencer_top.sv
dv/drum_trigger_step_sequencer_top_tb.sv
